@@ hdl/owts_pkg.sv @@
package owts_pkg;

	// Item codes
	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_CONVERT = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;

	// Sequencer phases
	localparam int PHASE_W = 4;
	localparam logic [PHASE_W-1:0] PH_IDLE          = 4'd0;
	localparam logic [PHASE_W-1:0] PH_RST_LOW       = 4'd1;
	localparam logic [PHASE_W-1:0] PH_PRES_WAIT     = 4'd2;
	localparam logic [PHASE_W-1:0] PH_RST_TAIL      = 4'd3;
	localparam logic [PHASE_W-1:0] PH_RST_TAIL_FAIL = 4'd4;
	localparam logic [PHASE_W-1:0] PH_WR_LOW        = 4'd5;
	localparam logic [PHASE_W-1:0] PH_WR_HIGH       = 4'd6;
	localparam logic [PHASE_W-1:0] PH_RD_LOW        = 4'd7;
	localparam logic [PHASE_W-1:0] PH_RD_WAIT       = 4'd8;
	localparam logic [PHASE_W-1:0] PH_RD_TAIL       = 4'd9;

	// Bus command bytes and failure word
	localparam logic [7:0]  CMD_SKIP_ROM = 8'hCC;
	localparam logic [7:0]  CMD_CONVERT  = 8'h44;
	localparam logic [7:0]  CMD_READ_SP  = 8'hBE;
	localparam logic [15:0] FAIL_WORD    = 16'h7FFF;
	localparam logic [7:0]  CRC_POLY     = 8'h8C;

	// Scratchpad length; the last byte carries the CRC
	localparam int SCRATCH_BYTES = 9;
	localparam int BYTE_IDX_W    = 4;
	localparam logic [BYTE_IDX_W-1:0] LAST_BYTE = BYTE_IDX_W'(SCRATCH_BYTES - 1);

	// Timing registers
	localparam int TIME_W = 10;
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRES_WAIT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_LONG    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_SHORT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_READ_LOW     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_READ_TAIL    = 3'd7;

	localparam logic [TIME_W-1:0] RST_RESET_LOW   = 10'd600;
	localparam logic [TIME_W-1:0] RST_PRES_WAIT   = 10'd60;
	localparam logic [TIME_W-1:0] RST_RESET_TAIL  = 10'd500;
	localparam logic [TIME_W-1:0] RST_SLOT_LONG   = 10'd80;
	localparam logic [TIME_W-1:0] RST_SLOT_SHORT  = 10'd8;
	localparam logic [TIME_W-1:0] RST_READ_LOW    = 10'd2;
	localparam logic [TIME_W-1:0] RST_READ_SAMPLE = 10'd5;
	localparam logic [TIME_W-1:0] RST_READ_TAIL   = 10'd60;

	typedef struct packed {
		logic [1:0] op;
		logic       line_level;
	} owts_item_t;

	typedef struct packed {
		logic        drive_low;
		logic        busy_res;
		logic        done_res;
		logic        ok;
		logic [15:0] temperature;
	} owts_result_t;

	typedef struct packed {
		logic [TIME_W-1:0] reset_low_time;
		logic [TIME_W-1:0] presence_wait_time;
		logic [TIME_W-1:0] reset_tail_time;
		logic [TIME_W-1:0] slot_long_time;
		logic [TIME_W-1:0] slot_short_time;
		logic [TIME_W-1:0] read_low_time;
		logic [TIME_W-1:0] read_sample_time;
		logic [TIME_W-1:0] read_tail_time;
	} owts_cfg_t;

	typedef struct packed {
		logic [PHASE_W-1:0]    phase;
		logic [TIME_W-1:0]     time_count;
		logic [2:0]            bit_index;
		logic [BYTE_IDX_W-1:0] byte_index;
		logic [7:0]            shift_byte;
		logic [7:0]            crc_value;
		logic [15:0]           temp_word;
		logic                  read_mode;
	} owts_state_t;

	// Reflected CRC-8, one byte, LSB first
	function automatic logic [7:0] crc_feed(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] crc;
		logic [7:0] d;
		logic       mix;
		crc = crc_in;
		d = data;
		for (int j = 0; j < 8; j++) begin
			mix = crc[0] ^ d[0];
			crc = crc >> 1;
			if (mix) begin
				crc = crc ^ CRC_POLY;
			end
			d = d >> 1;
		end
		return crc;
	endfunction

endpackage

@@ hdl/owts_step.sv @@
module owts_step (
	input  owts_pkg::owts_state_t  cur,
	input  owts_pkg::owts_item_t   item,
	input  owts_pkg::owts_cfg_t    cfg,
	output owts_pkg::owts_state_t  nxt,
	output owts_pkg::owts_result_t res
);
	import owts_pkg::*;

	logic [TIME_W-1:0] cnt1;
	logic [TIME_W-1:0] lim;
	logic              expired;
	logic              timed;
	logic [2:0]        bit_nxt;
	logic [BYTE_IDX_W-1:0] byte_nxt;
	logic              crc_match;

	// Limit of the running phase; write slots depend on the current bit
	always_comb begin
		timed = 1'b1;
		lim = cfg.reset_low_time;
		case (cur.phase)
			PH_RST_LOW:       lim = cfg.reset_low_time;
			PH_PRES_WAIT:     lim = cfg.presence_wait_time;
			PH_RST_TAIL,
			PH_RST_TAIL_FAIL: lim = cfg.reset_tail_time;
			PH_WR_LOW:        lim = cur.shift_byte[0] ? cfg.slot_short_time : cfg.slot_long_time;
			PH_WR_HIGH:       lim = cur.shift_byte[0] ? cfg.slot_long_time : cfg.slot_short_time;
			PH_RD_LOW:        lim = cfg.read_low_time;
			PH_RD_WAIT:       lim = cfg.read_sample_time;
			PH_RD_TAIL:       lim = cfg.read_tail_time;
			default:          timed = 1'b0;
		endcase
	end

	// Zero limit acts as one: a wrapped count also ends the phase
	assign cnt1      = cur.time_count + TIME_W'(1);
	assign expired   = (cnt1 >= lim) || (cnt1 == '0);
	assign bit_nxt   = cur.bit_index + 3'd1;
	assign byte_nxt  = cur.byte_index + BYTE_IDX_W'(1);
	assign crc_match = (cur.crc_value == cur.shift_byte);

	// Next state and result for one item
	always_comb begin
		nxt = cur;
		res = '0;
		case (item.op) inside
			OP_CONVERT, OP_READ: begin
				if (cur.phase == PH_IDLE) begin
					nxt.read_mode  = (item.op == OP_READ);
					nxt.phase      = PH_RST_LOW;
					nxt.time_count = '0;
					nxt.bit_index  = '0;
					nxt.byte_index = '0;
					nxt.shift_byte = '0;
					nxt.crc_value  = '0;
				end
			end
			OP_TICK: begin
				if (timed) begin
					nxt.time_count = expired ? '0 : cnt1;
				end
				unique case (cur.phase)
					PH_IDLE: ;
					PH_RST_LOW: begin
						if (expired) nxt.phase = PH_PRES_WAIT;
					end
					PH_PRES_WAIT: begin
						if (expired) nxt.phase = item.line_level ? PH_RST_TAIL_FAIL : PH_RST_TAIL;
					end
					PH_RST_TAIL_FAIL: begin
						if (expired) begin
							nxt.phase = PH_IDLE;
							res.done_res = 1'b1;
							res.temperature = FAIL_WORD;
						end
					end
					PH_RST_TAIL: begin
						if (expired) begin
							nxt.shift_byte = CMD_SKIP_ROM;
							nxt.bit_index  = '0;
							nxt.byte_index = '0;
							nxt.phase      = PH_WR_LOW;
						end
					end
					PH_WR_LOW: begin
						if (expired) nxt.phase = PH_WR_HIGH;
					end
					PH_WR_HIGH: begin
						if (expired) begin
							nxt.shift_byte = cur.shift_byte >> 1;
							nxt.bit_index  = bit_nxt;
							nxt.phase      = PH_WR_LOW;
							// Byte boundary: command byte, then read or finish
							if (bit_nxt == '0) begin
								nxt.byte_index = byte_nxt;
								if (byte_nxt == BYTE_IDX_W'(1)) begin
									nxt.shift_byte = cur.read_mode ? CMD_READ_SP : CMD_CONVERT;
								end else if (cur.read_mode) begin
									nxt.byte_index = '0;
									nxt.shift_byte = '0;
									nxt.crc_value  = '0;
									nxt.phase      = PH_RD_LOW;
								end else begin
									nxt.phase = PH_IDLE;
									res.done_res = 1'b1;
									res.ok = 1'b1;
								end
							end
						end
					end
					PH_RD_LOW: begin
						if (expired) nxt.phase = PH_RD_WAIT;
					end
					PH_RD_WAIT: begin
						if (expired) begin
							nxt.shift_byte[cur.bit_index] = cur.shift_byte[cur.bit_index]
								| item.line_level;
							nxt.phase = PH_RD_TAIL;
						end
					end
					PH_RD_TAIL: begin
						if (expired) begin
							nxt.bit_index = bit_nxt;
							nxt.phase     = PH_RD_LOW;
							if (bit_nxt == '0) begin
								if (cur.byte_index < LAST_BYTE) begin
									nxt.crc_value = crc_feed(cur.crc_value, cur.shift_byte);
									if (cur.byte_index == BYTE_IDX_W'(0)) begin
										nxt.temp_word[7:0] = cur.shift_byte;
									end else if (cur.byte_index == BYTE_IDX_W'(1)) begin
										nxt.temp_word[15:8] = cur.shift_byte;
									end
									nxt.shift_byte = '0;
									nxt.byte_index = byte_nxt;
								end else begin
									// CRC byte in: check and finish
									res.ok = crc_match;
									res.temperature = crc_match ? cur.temp_word : FAIL_WORD;
									res.done_res = 1'b1;
									nxt.shift_byte = '0;
									nxt.phase = PH_IDLE;
								end
							end
						end
					end
					default: nxt.phase = PH_IDLE;
				endcase
			end
			default: ;
		endcase
		res.drive_low = (nxt.phase == PH_RST_LOW) || (nxt.phase == PH_WR_LOW)
			|| (nxt.phase == PH_RD_LOW);
		res.busy_res = (nxt.phase != PH_IDLE);
	end

endmodule

@@ hdl/one_wire_thermometer_sequencer.sv @@
// One-wire bus master for a single temperature sensor. Feed one tick item per
// microsecond with the sampled bus level, or a command item (start conversion
// or read temperature); every item returns exactly one result with the bus
// drive, busy and, on the finishing item, done/ok/temperature. One item per
// clock is sustained while results are taken: an item passes an input register,
// the sequencer step logic and a result register, which loads when it is free
// or draining, and a stalled result does not stop the next item from entering
// the input register. Timing registers are written through cfg_we/cfg_index/
// cfg_data and take effect from the next item.
module one_wire_thermometer_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  owts_pkg::owts_item_t            cmd,
	output logic                            res_valid,
	input  logic                            res_ready,
	output owts_pkg::owts_result_t          res,
	input  logic                            cfg_we,
	input  logic [owts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [owts_pkg::TIME_W-1:0]     cfg_data
);
	import owts_pkg::*;

	owts_item_t   item_s1;
	logic         valid_s1;
	owts_state_t  state_q;
	owts_state_t  state_nxt;
	owts_cfg_t    cfg_q;
	owts_result_t res_nxt;
	owts_result_t res_q;
	logic         res_valid_q;
	logic         advance;

	// Input register moves on when the result register is free or draining
	assign advance   = valid_s1 && (!res_valid_q || res_ready);
	assign cmd_ready = !valid_s1 || advance;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_time     <= RST_RESET_LOW;
			cfg_q.presence_wait_time <= RST_PRES_WAIT;
			cfg_q.reset_tail_time    <= RST_RESET_TAIL;
			cfg_q.slot_long_time     <= RST_SLOT_LONG;
			cfg_q.slot_short_time    <= RST_SLOT_SHORT;
			cfg_q.read_low_time      <= RST_READ_LOW;
			cfg_q.read_sample_time   <= RST_READ_SAMPLE;
			cfg_q.read_tail_time     <= RST_READ_TAIL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RESET_LOW:   cfg_q.reset_low_time     <= cfg_data;
				REG_PRES_WAIT:   cfg_q.presence_wait_time <= cfg_data;
				REG_RESET_TAIL:  cfg_q.reset_tail_time    <= cfg_data;
				REG_SLOT_LONG:   cfg_q.slot_long_time     <= cfg_data;
				REG_SLOT_SHORT:  cfg_q.slot_short_time    <= cfg_data;
				REG_READ_LOW:    cfg_q.read_low_time      <= cfg_data;
				REG_READ_SAMPLE: cfg_q.read_sample_time   <= cfg_data;
				REG_READ_TAIL:   cfg_q.read_tail_time     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_valid && cmd_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			item_s1 <= cmd;
		end
	end

	owts_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.cfg  (cfg_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Sequencer state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			state_q     <= state_nxt;
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

endmodule

@@ hdl/owts_checker.sv @@
module owts_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   res_valid,
	input logic                   res_ready,
	input owts_pkg::owts_result_t res
);
	import owts_pkg::*;

	// A stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// ok only on a finishing item
	a_ok_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.ok |-> res.done_res)
		else $error("ok without done");

	// A finished command leaves the bus idle and released
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.done_res |-> !res.busy_res && !res.drive_low)
		else $error("done while busy");

	// Bus is only pulled during a sequence
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.drive_low |-> res.busy_res)
		else $error("bus driven while idle");

	// Temperature is zero except on the finishing item
	a_temp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.done_res |-> res.temperature == '0)
		else $error("temperature without done");

endmodule

bind one_wire_thermometer_sequencer owts_checker u_owts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

@@ tb/one_wire_thermometer_sequencer_tb.sv @@
module one_wire_thermometer_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import owts_pkg::*;

	// op code with no meaning to the sequencer
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 1_200_000;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_ready;
	owts_item_t           cmd = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	owts_result_t         res;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TIME_W-1:0]    cfg_data = '0;

	// handshake pacing, in percent of cycles
	int unsigned send_gap_pct;
	int unsigned recv_stall_pct;

	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned live_items = 0;

	owts_result_t predicted_status[$];

	// sequencer model state
	logic [TIME_W-1:0]     timing [8] = '{RST_RESET_LOW, RST_PRES_WAIT, RST_RESET_TAIL,
		RST_SLOT_LONG, RST_SLOT_SHORT, RST_READ_LOW, RST_READ_SAMPLE, RST_READ_TAIL};
	logic [PHASE_W-1:0]    ph = PH_IDLE;
	logic [TIME_W-1:0]     tcount = '0;
	logic [2:0]            bit_pos = '0;
	logic [BYTE_IDX_W-1:0] byte_pos = '0;
	logic [7:0]            shreg = '0;
	logic [7:0]            crc_acc = '0;
	logic [15:0]           temp_acc = '0;
	logic                  reading = 1'b0;

	// sensor side: scratchpad contents and presence answer
	logic [7:0] scratchpad [SCRATCH_BYTES];
	logic       sensor_present = 1'b1;

	one_wire_thermometer_sequencer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** one_wire_thermometer_sequencer: FAILED **");
			$finish;
		end
	end

	// reflected CRC-8 over one byte, LSB first
	function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
		logic [7:0] c;
		c = acc;
		for (int k = 0; k < 8; k++) begin
			c = (c[0] ^ data[k]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// true when the next tick closes a phase of the given length
	function automatic bit ends_on_tick(input logic [TIME_W-1:0] limit);
		logic [TIME_W-1:0] nxt;
		nxt = tcount + 1'b1;
		return (nxt >= limit) || (nxt == '0);
	endfunction

	function automatic bit phase_expired(input logic [TIME_W-1:0] limit);
		bit fin;
		fin = ends_on_tick(limit);
		tcount = fin ? '0 : tcount + 1'b1;
		return fin;
	endfunction

	// one item through the sequencer model; returns the bus status it causes
	function automatic owts_result_t advance_sequencer(input owts_item_t it);
		owts_result_t r;
		logic wbit;
		r = '0;
		wbit = shreg[0];
		if (it.op == OP_CONVERT || it.op == OP_READ) begin
			if (ph == PH_IDLE) begin
				reading = (it.op == OP_READ);
				ph = PH_RST_LOW;
				tcount = '0;
				bit_pos = '0;
				byte_pos = '0;
				shreg = '0;
				crc_acc = '0;
			end
		end else if (it.op == OP_TICK) begin
			case (ph)
				PH_RST_LOW: begin
					if (phase_expired(timing[REG_RESET_LOW])) ph = PH_PRES_WAIT;
				end
				PH_PRES_WAIT: begin
					if (phase_expired(timing[REG_PRES_WAIT]))
						ph = it.line_level ? PH_RST_TAIL_FAIL : PH_RST_TAIL;
				end
				PH_RST_TAIL_FAIL: begin
					if (phase_expired(timing[REG_RESET_TAIL])) begin
						ph = PH_IDLE;
						r.done_res = 1'b1;
						r.temperature = FAIL_WORD;
					end
				end
				PH_RST_TAIL: begin
					if (phase_expired(timing[REG_RESET_TAIL])) begin
						shreg = CMD_SKIP_ROM;
						bit_pos = '0;
						byte_pos = '0;
						ph = PH_WR_LOW;
					end
				end
				PH_WR_LOW: begin
					if (phase_expired(wbit ? timing[REG_SLOT_SHORT] : timing[REG_SLOT_LONG]))
						ph = PH_WR_HIGH;
				end
				PH_WR_HIGH: begin
					if (phase_expired(wbit ? timing[REG_SLOT_LONG] : timing[REG_SLOT_SHORT])) begin
						shreg = shreg >> 1;
						bit_pos = bit_pos + 1'b1;
						ph = PH_WR_LOW;
						if (bit_pos == '0) begin
							byte_pos = byte_pos + 1'b1;
							if (byte_pos == 1) begin
								shreg = reading ? CMD_READ_SP : CMD_CONVERT;
							end else if (reading) begin
								byte_pos = '0;
								shreg = '0;
								crc_acc = '0;
								ph = PH_RD_LOW;
							end else begin
								ph = PH_IDLE;
								r.done_res = 1'b1;
								r.ok = 1'b1;
							end
						end
					end
				end
				PH_RD_LOW: begin
					if (phase_expired(timing[REG_READ_LOW])) ph = PH_RD_WAIT;
				end
				PH_RD_WAIT: begin
					if (phase_expired(timing[REG_READ_SAMPLE])) begin
						shreg[bit_pos] = shreg[bit_pos] | it.line_level;
						ph = PH_RD_TAIL;
					end
				end
				PH_RD_TAIL: begin
					if (phase_expired(timing[REG_READ_TAIL])) begin
						bit_pos = bit_pos + 1'b1;
						ph = PH_RD_LOW;
						if (bit_pos == '0) begin
							if (byte_pos < LAST_BYTE) begin
								crc_acc = crc8_step(crc_acc, shreg);
								if (byte_pos == 0) temp_acc[7:0] = shreg;
								else if (byte_pos == 1) temp_acc[15:8] = shreg;
								shreg = '0;
								byte_pos = byte_pos + 1'b1;
							end else begin
								r.ok = (crc_acc == shreg);
								r.temperature = r.ok ? temp_acc : FAIL_WORD;
								r.done_res = 1'b1;
								shreg = '0;
								ph = PH_IDLE;
							end
						end
					end
				end
				default: begin
					ph = PH_IDLE;
				end
			endcase
		end
		r.drive_low = (ph == PH_RST_LOW) || (ph == PH_WR_LOW) || (ph == PH_RD_LOW);
		r.busy_res = (ph != PH_IDLE);
		return r;
	endfunction

	// level the sensor puts on the bus for the coming tick
	function automatic logic bus_level();
		logic want;
		logic [TIME_W-1:0] lim;
		if (ph == PH_PRES_WAIT) begin
			want = !sensor_present;
			lim = timing[REG_PRES_WAIT];
		end else if (ph == PH_RD_WAIT) begin
			want = scratchpad[byte_pos][bit_pos];
			lim = timing[REG_READ_SAMPLE];
		end else begin
			return 1'($urandom_range(0, 1));
		end
		// glitches only on ticks that are not sampled
		if (!ends_on_tick(lim) && $urandom_range(0, 9) == 0) return !want;
		return want;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// result side: random stalls and comparison against the oldest prediction
	always @(posedge clk) begin : status_checker
		owts_result_t want;
		res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		if (arst_n && res_valid && res_ready) begin
			if (predicted_status.size() == 0) begin
				$error("status with no item outstanding: %p", res);
				mismatches++;
			end else begin
				want = predicted_status.pop_front();
				check_field("drive_low", want.drive_low, res.drive_low);
				check_field("busy_res", want.busy_res, res.busy_res);
				check_field("done_res", want.done_res, res.done_res);
				check_field("ok", want.ok, res.ok);
				check_field("temperature", want.temperature, res.temperature);
			end
		end
	end

	// hand one item to the block and record what it should produce
	task automatic send_item(input owts_item_t it);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd <= it;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		if (it.op == OP_TICK ? ph != PH_IDLE
				: ((it.op == OP_CONVERT || it.op == OP_READ) && ph == PH_IDLE))
			live_items++;
		predicted_status.push_back(advance_sequencer(it));
	endtask

	// stop sending and wait for every outstanding status
	task automatic settle_bus();
		cmd_valid <= 1'b0;
		while (predicted_status.size() != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// only called with the block idle
	task automatic write_timing(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		timing[idx] = val;
	endtask

	task automatic load_scratchpad(input logic [7:0] lo, input logic [7:0] hi, input bit bad_crc);
		logic [7:0] c;
		c = '0;
		scratchpad[0] = lo;
		scratchpad[1] = hi;
		for (int i = 2; i < SCRATCH_BYTES - 1; i++) scratchpad[i] = 8'($urandom_range(0, 255));
		for (int i = 0; i < SCRATCH_BYTES - 1; i++) c = crc8_step(c, scratchpad[i]);
		scratchpad[SCRATCH_BYTES - 1] = bad_crc ? c ^ 8'($urandom_range(1, 255)) : c;
	endtask

	// one full command, ticking until the sequencer is idle again;
	// stray commands land while busy and must be ignored
	task automatic run_command(input logic [1:0] which, input bit present,
			input int unsigned stray_pct);
		owts_item_t it;
		sensor_present = present;
		it.op = which;
		it.line_level = 1'($urandom_range(0, 1));
		send_item(it);
		while (ph != PH_IDLE) begin
			if ($urandom_range(0, 99) < stray_pct) begin
				case ($urandom_range(0, 2))
					0: it.op = OP_CONVERT;
					1: it.op = OP_READ;
					default: it.op = OP_UNUSED;
				endcase
				it.line_level = 1'($urandom_range(0, 1));
			end else begin
				it.op = OP_TICK;
				it.line_level = bus_level();
			end
			send_item(it);
		end
	endtask

	// ticks and the unused op while idle, both line levels
	task automatic test_idle_items();
		owts_item_t it;
		it.op = OP_TICK;
		it.line_level = 1'b0;
		send_item(it);
		it.line_level = 1'b1;
		send_item(it);
		it.op = OP_UNUSED;
		send_item(it);
		it.line_level = 1'b0;
		send_item(it);
	endtask

	// a conversion on the timing the block comes out of reset with
	task automatic test_reset_values();
		run_command(OP_CONVERT, 1'b1, 2);
	endtask

	task automatic test_directed_commands();
		settle_bus();
		write_timing(REG_RESET_LOW, 10'd3);
		write_timing(REG_PRES_WAIT, 10'd2);
		write_timing(REG_RESET_TAIL, 10'd2);
		write_timing(REG_SLOT_LONG, 10'd3);
		write_timing(REG_SLOT_SHORT, 10'd1);
		write_timing(REG_READ_LOW, 10'd1);
		write_timing(REG_READ_SAMPLE, 10'd2);
		write_timing(REG_READ_TAIL, 10'd1);
		load_scratchpad(8'hFF, 8'hFF, 1'b0);
		run_command(OP_READ, 1'b1, 0);
		load_scratchpad(8'h00, 8'h00, 1'b0);
		run_command(OP_READ, 1'b1, 0);
		load_scratchpad(8'h5A, 8'hA5, 1'b1);
		run_command(OP_READ, 1'b1, 0);
		run_command(OP_READ, 1'b0, 0);
		run_command(OP_CONVERT, 1'b0, 0);
		run_command(OP_CONVERT, 1'b1, 10);
	endtask

	// a zero register must act as one
	task automatic test_zero_timing();
		settle_bus();
		for (int i = 0; i < 8; i++) write_timing(CFG_IDX_W'(i), '0);
		load_scratchpad(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
		run_command(OP_READ, 1'b1, 5);
		run_command(OP_CONVERT, 1'b0, 0);
	endtask

	task automatic test_random_traffic(input int unsigned target);
		int unsigned start_count;
		int unsigned cap;
		logic [CFG_IDX_W-1:0] idx;
		owts_item_t it;
		start_count = live_items;
		while (live_items - start_count < target) begin
			// occasional retiming; the bus drains first
			if ($urandom_range(0, 3) == 0) begin
				settle_bus();
				repeat ($urandom_range(1, 8)) begin
					idx = CFG_IDX_W'($urandom_range(0, 7));
					cap = (idx <= REG_RESET_TAIL) ? 6 : ((idx <= REG_SLOT_SHORT) ? 4 : 3);
					write_timing(idx, TIME_W'($urandom_range(0, cap)));
				end
			end
			// ignored items between commands
			repeat ($urandom_range(0, 2)) begin
				it.op = $urandom_range(0, 1) ? OP_TICK : OP_UNUSED;
				it.line_level = 1'($urandom_range(0, 1));
				send_item(it);
			end
			if ($urandom_range(0, 1)) begin
				load_scratchpad(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					$urandom_range(0, 4) == 0);
				run_command(OP_READ, $urandom_range(0, 9) != 0, 3);
			end else begin
				run_command(OP_CONVERT, $urandom_range(0, 9) != 0, 3);
			end
		end
	endtask

	// reset low time at its top value through a full conversion
	task automatic test_max_timing();
		settle_bus();
		write_timing(REG_RESET_LOW, TIME_MAX);
		run_command(OP_CONVERT, 1'b1, 0);
	endtask

	initial begin
		send_gap_pct = 20;
		recv_stall_pct = 81;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_items();
		test_reset_values();
		test_directed_commands();
		test_zero_timing();
		test_random_traffic(350);

		send_gap_pct = 81;
		recv_stall_pct = 20;
		test_random_traffic(350);

		send_gap_pct = 0;
		recv_stall_pct = 0;
		test_random_traffic(350);
		test_max_timing();

		settle_bus();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("** one_wire_thermometer_sequencer: PASSED **");
		end else begin
			$display("** one_wire_thermometer_sequencer: FAILED **");
		end
		$finish;
	end

endmodule
